// ----- rtl/core/cmpcal_pkg.sv -----
package cmpcal_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int HEAD_W    = 16;

  // cordic datapath widths: products reach 2^31, gain and pre-rotation stay under 2^34
  localparam int DATA_W    = 36;
  localparam int PROD_W    = 33;
  localparam int ANG_W     = 25;

  // arctangent table
  localparam int TBL_LEN   = 24;
  localparam int TBL_IDX_W = 5;

  localparam int CORDIC_STEPS_DEF = 16;

  // angles in 1/32768 degree inside, 1/128 degree at the result
  localparam logic signed [ANG_W-1:0]  DEG90        = 25'sd2949120;
  localparam logic signed [HEAD_W-1:0] HALF_TURN    = 16'sd23040;
  localparam logic signed [HEAD_W-1:0] QUARTER_TURN = 16'sd11520;
  localparam int RND_BIAS  = 128;
  localparam int RND_SHIFT = 8;

  // operands handed from calibration to the angle unit
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cx;
    logic signed [SAMPLE_W-1:0] cz;
    logic [SAMPLE_W-1:0]        xr;
    logic [SAMPLE_W-1:0]        zr;
  } op_t;

  // finished heading
  typedef struct packed {
    logic signed [HEAD_W-1:0] heading;
    logic                     heading_valid;
  } res_t;

  // atan(2^-i) in 1/32768 degree, rounded
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [TBL_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      5'd0:    val = 25'sd1474560;
      5'd1:    val = 25'sd870484;
      5'd2:    val = 25'sd459940;
      5'd3:    val = 25'sd233473;
      5'd4:    val = 25'sd117189;
      5'd5:    val = 25'sd58652;
      5'd6:    val = 25'sd29333;
      5'd7:    val = 25'sd14667;
      5'd8:    val = 25'sd7334;
      5'd9:    val = 25'sd3667;
      5'd10:   val = 25'sd1833;
      5'd11:   val = 25'sd917;
      5'd12:   val = 25'sd458;
      5'd13:   val = 25'sd229;
      5'd14:   val = 25'sd115;
      5'd15:   val = 25'sd57;
      5'd16:   val = 25'sd29;
      5'd17:   val = 25'sd14;
      5'd18:   val = 25'sd7;
      5'd19:   val = 25'sd4;
      5'd20:   val = 25'sd2;
      5'd21:   val = 25'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- rtl/core/cmpcal_if.sv -----
interface cmpcal_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [cmpcal_pkg::SAMPLE_W-1:0]   sample_x;
  logic signed [cmpcal_pkg::SAMPLE_W-1:0]   sample_z;

  modport source (output valid, output sample_x, output sample_z, input ready);
  modport sink (input valid, input sample_x, input sample_z, output ready);
endinterface

interface cmpcal_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [cmpcal_pkg::HEAD_W-1:0]     heading;
  logic                                     heading_valid;

  modport source (output valid, output heading, output heading_valid, input ready);
  modport sink (input valid, input heading, input heading_valid, output ready);
endinterface

// ----- rtl/core/cmpcal_calib.sv -----
module cmpcal_calib (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  logic signed [cmpcal_pkg::SAMPLE_W-1:0] sample_x,
  input  logic signed [cmpcal_pkg::SAMPLE_W-1:0] sample_z,
  input  logic                                   track,
  input  logic                                   center,
  output cmpcal_pkg::op_t                        op
);

  localparam int SW = cmpcal_pkg::SAMPLE_W;

  logic                 first_r, first_nxt;
  logic signed [SW-1:0] xmax_r, xmax_nxt, xmin_r, xmin_nxt;
  logic signed [SW-1:0] zmax_r, zmax_nxt, zmin_r, zmin_nxt;
  logic signed [SW-1:0] sx_r, sz_r;
  cmpcal_pkg::op_t      op_r, op_nxt;

  logic signed [SW-1:0] xmax_b, xmin_b, zmax_b, zmin_b;
  logic signed [SW:0]   xsum, zsum, xsum_adj, zsum_adj, xhalf, zhalf;

  // extremes update on an input transfer
  always_comb begin
    xmax_b = first_r ? sample_x : xmax_r;
    xmin_b = first_r ? sample_x : xmin_r;
    zmax_b = first_r ? sample_z : zmax_r;
    zmin_b = first_r ? sample_z : zmin_r;
    xmax_nxt = xmax_r;
    xmin_nxt = xmin_r;
    zmax_nxt = zmax_r;
    zmin_nxt = zmin_r;
    first_nxt = first_r;
    if (load) begin
      first_nxt = 1'b0;
      xmax_nxt = (track && sample_x > xmax_b) ? sample_x : xmax_b;
      xmin_nxt = (track && sample_x < xmin_b) ? sample_x : xmin_b;
      zmax_nxt = (track && sample_z > zmax_b) ? sample_z : zmax_b;
      zmin_nxt = (track && sample_z < zmin_b) ? sample_z : zmin_b;
    end
  end

  // centers truncated toward zero, centered samples and spans
  always_comb begin
    xsum = {xmax_r[SW-1], xmax_r} + {xmin_r[SW-1], xmin_r};
    zsum = {zmax_r[SW-1], zmax_r} + {zmin_r[SW-1], zmin_r};
    xsum_adj = xsum + $signed({{SW{1'b0}}, xsum[SW]});
    zsum_adj = zsum + $signed({{SW{1'b0}}, zsum[SW]});
    xhalf = xsum_adj >>> 1;
    zhalf = zsum_adj >>> 1;
    op_nxt = op_r;
    if (center) begin
      op_nxt.cx = SW'(sx_r - xhalf[SW-1:0]);
      op_nxt.cz = SW'(sz_r - zhalf[SW-1:0]);
      op_nxt.xr = SW'(xmax_r - xmin_r);
      op_nxt.zr = SW'(zmax_r - zmin_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      xmax_r  <= '0;
      xmin_r  <= '0;
      zmax_r  <= '0;
      zmin_r  <= '0;
    end else begin
      first_r <= first_nxt;
      xmax_r  <= xmax_nxt;
      xmin_r  <= xmin_nxt;
      zmax_r  <= zmax_nxt;
      zmin_r  <= zmin_nxt;
    end
  end

  // sample and operand registers
  always_ff @(posedge clk) begin
    if (load) begin
      sx_r <= sample_x;
      sz_r <= sample_z;
    end
    op_r <= op_nxt;
  end

  assign op = op_r;

  // once seeded, the extremes never cross
  a_x_order: assert property (@(posedge clk) disable iff (!rst_n)
    !first_r |-> xmax_r >= xmin_r) else $error("x extremes crossed");
  a_z_order: assert property (@(posedge clk) disable iff (!rst_n)
    !first_r |-> zmax_r >= zmin_r) else $error("z extremes crossed");
  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    load && first_r |=> xmax_r == sx_r || xmin_r == sx_r) else $error("first sample not seeded");

endmodule

// ----- rtl/core/cmpcal_cordic.sv -----
module cmpcal_cordic #(
  parameter int CORDIC_STEPS = cmpcal_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  cmpcal_pkg::op_t  op,
  output logic             busy,
  output logic             done,
  output cmpcal_pkg::res_t res
);

  localparam int DW    = cmpcal_pkg::DATA_W;
  localparam int PW    = cmpcal_pkg::PROD_W;
  localparam int AW    = cmpcal_pkg::ANG_W;
  localparam int HW    = cmpcal_pkg::HEAD_W;
  localparam int SW    = cmpcal_pkg::SAMPLE_W;
  // rotation count, capped at the table length
  localparam int STEPS = (CORDIC_STEPS > cmpcal_pkg::TBL_LEN) ?
                         cmpcal_pkg::TBL_LEN : CORDIC_STEPS;
  localparam int CNT_W = $clog2(STEPS);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_MULY = 3'd1;
  localparam logic [2:0] C_MULX = 3'd2;
  localparam logic [2:0] C_PRE  = 3'd3;
  localparam logic [2:0] C_ROT  = 3'd4;
  localparam logic [2:0] C_RND  = 3'd5;
  localparam logic [2:0] C_DONE = 3'd6;

  localparam logic signed [AW:0] HALF_W  = (AW+1)'(cmpcal_pkg::HALF_TURN);
  localparam logic signed [AW:0] NHALF_W = -HALF_W;

  logic [2:0]           state_r, state_nxt;
  logic signed [DW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [AW-1:0] z_r, z_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  cmpcal_pkg::res_t     res_r, res_nxt;

  logic signed [SW-1:0] mul_a;
  logic [SW-1:0]        mul_b;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] xs, ys;
  logic signed [AW-1:0] ang;
  logic signed [AW:0]   zb, rnd;

  // shared multiplier: y operand first, then x operand
  always_comb begin
    mul_a = (state_r == C_MULY) ? op.cx : op.cz;
    mul_b = (state_r == C_MULY) ? op.zr : op.xr;
    prod  = mul_a * $signed({1'b0, mul_b});
  end

  // shift-add step and rounding
  always_comb begin
    xs  = x_r >>> cnt_r;
    ys  = y_r >>> cnt_r;
    ang = cmpcal_pkg::atan_entry(cmpcal_pkg::TBL_IDX_W'(cnt_r));
    zb  = (AW+1)'(z_r) + (AW+1)'(cmpcal_pkg::RND_BIAS);
    rnd = zb >>> cmpcal_pkg::RND_SHIFT;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) state_nxt = C_MULY;
      end
      C_MULY: begin
        y_nxt     = DW'(prod);
        state_nxt = C_MULX;
      end
      C_MULX: begin
        x_nxt     = DW'(prod);
        state_nxt = C_PRE;
      end
      C_PRE: begin
        res_nxt.heading_valid = (op.zr != '0);
        res_nxt.heading       = '0;
        cnt_nxt               = '0;
        z_nxt                 = '0;
        state_nxt             = C_DONE;
        if (op.zr == '0) begin
          res_nxt.heading = '0;
        end else if (y_r == '0) begin
          res_nxt.heading = (x_r < 0) ? cmpcal_pkg::HALF_TURN : '0;
        end else if (x_r == '0) begin
          res_nxt.heading = (y_r > 0) ? cmpcal_pkg::QUARTER_TURN : -cmpcal_pkg::QUARTER_TURN;
        end else begin
          state_nxt = C_ROT;
          // rotate into the right half plane
          if (x_r < 0) begin
            if (y_r >= 0) begin
              x_nxt = y_r;
              y_nxt = -x_r;
              z_nxt = cmpcal_pkg::DEG90;
            end else begin
              x_nxt = -y_r;
              y_nxt = x_r;
              z_nxt = -cmpcal_pkg::DEG90;
            end
          end
        end
      end
      C_ROT: begin
        if (y_r >= 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + ang;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - ang;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) state_nxt = C_RND;
      end
      C_RND: begin
        if (rnd > HALF_W) begin
          res_nxt.heading = cmpcal_pkg::HALF_TURN;
        end else if (rnd < NHALF_W) begin
          res_nxt.heading = -cmpcal_pkg::HALF_TURN;
        end else begin
          res_nxt.heading = HW'(rnd);
        end
        state_nxt = C_DONE;
      end
      C_DONE: begin
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    cnt_r <= cnt_nxt;
    res_r <= res_nxt;
  end

  assign busy = (state_r != C_IDLE);
  assign done = (state_r == C_DONE);
  assign res  = res_r;

  // rotation stays in the right half plane, and start only lands on an idle unit
  a_rot_x: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_ROT |-> !x_r[DW-1]) else $error("cordic x went negative");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == C_IDLE) else $error("start while busy");
  a_done_seq: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(state_r) == C_PRE || $past(state_r) == C_RND) else $error("bad done path");

endmodule

// ----- rtl/core/compass_heading_with_auto_calibration.sv -----
// Compass heading with hard-iron auto calibration.
// in_ch carries one signed X and one signed Z magnetometer sample per transfer.
// out_ch returns one result per input: heading in 1/128 degree (-23040..23040)
// and heading_valid, which is low (with heading 0) while the Z span is zero.
// cfg_we/cfg_wdata write track_extremes: 1 widens the running min/max with
// each sample, 0 freezes them; the first sample after reset always seeds them.
// An item with a general angle passes, after its transfer, the centering step,
// the two multiplies (y operand, then x operand), the pre-rotation, the
// rotation loop and rounding before it reaches the output register;
// degenerate and on-axis cases skip the rotation loop and rounding. The
// iterative CORDIC loop does one shift-add step per cycle on one shared
// datapath; in_ch takes a new item only once the previous one has reached the output register.
// The step count is capped at the 24 entries of the angle table.
// Reset (rst_n low, synchronous) sets track_extremes to 1, marks the next
// sample as the seed and empties the output register.
// A finished result waits in the output register while out_ch.ready is low;
// the next item is accepted and computed meanwhile and holds at the end of its
// computation until the output register frees up.
module compass_heading_with_auto_calibration #(
  parameter int CORDIC_STEPS = cmpcal_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cmpcal_in_if.sink    in_ch,
  cmpcal_out_if.source out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CENTER = 2'd1;
  localparam logic [1:0] S_RUN    = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic             track_r;
  logic             in_xfer, out_load;
  logic             ovalid_r, ovalid_nxt;
  cmpcal_pkg::res_t ores_r;
  cmpcal_pkg::op_t  op;
  cmpcal_pkg::res_t res;
  logic             busy, done;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_HOLD) && (!ovalid_r || out_ch.ready);

  cmpcal_calib u_calib (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_xfer),
    .sample_x (in_ch.sample_x),
    .sample_z (in_ch.sample_z),
    .track    (track_r),
    .center   (state_r == S_CENTER),
    .op       (op)
  );

  cmpcal_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_CENTER),
    .op    (op),
    .busy  (busy),
    .done  (done),
    .res   (res)
  );

  // item sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_CENTER;
      S_CENTER: state_nxt = S_RUN;
      S_RUN:    if (done) state_nxt = S_HOLD;
      S_HOLD:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // output register valid
  assign ovalid_nxt = (ovalid_r && !out_ch.ready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      track_r  <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) track_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) ores_r <= res;
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.heading       = ores_r.heading;
  assign out_ch.heading_valid = ores_r.heading_valid;

  // sequencer and angle unit agree, results are well formed
  a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !busy) else $error("angle unit busy while idle");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.heading_valid |-> out_ch.heading == '0)
    else $error("invalid heading not zero");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.heading <= cmpcal_pkg::HALF_TURN
                  && out_ch.heading >= -cmpcal_pkg::HALF_TURN)
    else $error("heading out of range");
  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> state_r == S_IDLE && out_ch.valid) else $error("result load lost");

endmodule
